/* src/lrt_pkg.sv */
// package: command, event and sequencer codes for the lru route table
package lrt_pkg;

  localparam int TABLE_DEPTH_DEF  = 16;
  localparam int STATION_BITS_DEF = 16;
  localparam int TIME_BITS_DEF    = 32;

  localparam int MAX_RESULTS = 16;
  localparam int RES_BITS    = 5;

  localparam logic [4:0]  LIMIT_RESET   = 5'd16;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam logic [3:0] REG_TABLE_LIMIT    = 4'd0;
  localparam logic [3:0] REG_EXPIRY_TIMEOUT = 4'd1;

  localparam logic [2:0] CMD_UPDATE = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_EXPIRE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [2:0] EV_ADDED   = 3'd0;
  localparam logic [2:0] EV_UPDATED = 3'd1;
  localparam logic [2:0] EV_REMOVED = 3'd2;
  localparam logic [2:0] EV_HIT     = 3'd3;
  localparam logic [2:0] EV_MISS    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_EVICT,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic emit;
    logic flush;
  } out_ctl_t;

endpackage

/* src/lru_route_table.sv */
// top level: lru route table with a one-entry-per-cycle sequencer
//
// usage
//   start/busy command channel: a word is taken when start is high and busy low.
//   cfg_valid/cfg_ready write channel: index 0 table_limit, 1 expiry_timeout;
//   cfg_ready is always high; writes are to be made while busy is low, which the block itself does not enforce.
//   results leave one word per strobe cycle; last marks the final word of a
//   command. the receiver cannot stall, so there is no back pressure.
// sequencing
//   the table is kept as a list in recency order, and one comparator walks it
//   one position per cycle. an update that finds no match goes on to evict
//   entries from the tail while the table is at its limit, then adds the new
//   entry at the front; remove, expire and clear visit the positions in turn.
//   busy stays high until the last word is out.
// reset
//   rst empties the table and restores table_limit 16, expiry_timeout 1000.
module lru_route_table #(
  parameter int TABLE_DEPTH  = lrt_pkg::TABLE_DEPTH_DEF,
  parameter int STATION_BITS = lrt_pkg::STATION_BITS_DEF,
  parameter int TIME_BITS    = lrt_pkg::TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              cmd,
  input  logic [TIME_BITS-1:0]    now_ticks,
  input  logic [STATION_BITS-1:0] dest_id,
  input  logic [STATION_BITS-1:0] transit_id,
  input  logic [7:0]              hop_length,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [3:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  output logic                    strobe,
  output logic [2:0]              event_kind,
  output logic [STATION_BITS-1:0] route_dest,
  output logic [STATION_BITS-1:0] route_transit,
  output logic [7:0]              route_length,
  output logic [TIME_BITS-1:0]    route_expiry,
  output logic                    last
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 2 * STATION_BITS + 8 + TIME_BITS;
  localparam int RB = lrt_pkg::RES_BITS;

  lrt_pkg::state_t state, state_next;

  logic [EW-1:0]           ent [TABLE_DEPTH];
  logic [CW-1:0]           count;
  logic [CW-1:0]           pos;
  logic [RB-1:0]           nres;
  logic [4:0]              table_limit;
  logic [31:0]             expiry_timeout;
  logic [2:0]              cmd_r;
  logic [STATION_BITS-1:0] dest_r;
  logic [STATION_BITS-1:0] trn_r;
  logic [7:0]              len_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [TIME_BITS-1:0]    exp_r;

  logic [TIME_BITS+31:0]   to_wide;
  logic [IW-1:0]           idx;
  logic [IW-1:0]           tail;
  logic [EW-1:0]           cur;
  logic [EW-1:0]           tail_e;
  logic [EW-1:0]           new_e;
  logic                    at_end;
  logic                    dest_hit;
  logic                    improve;
  logic                    sweep_hit;
  logic                    evict_go;
  logic                    room;
  logic [7:0]              lim8;
  logic [7:0]              cnt8;
  logic                    accept;
  logic                    pend_valid;

  lrt_pkg::out_ctl_t       ctl;
  logic [2:0]              o_kind;
  logic [EW-1:0]           o_ent;

  function automatic logic [STATION_BITS-1:0] f_dest(input logic [EW-1:0] e);
    f_dest = e[EW-1 -: STATION_BITS];
  endfunction
  function automatic logic [STATION_BITS-1:0] f_trn(input logic [EW-1:0] e);
    f_trn = e[TIME_BITS+8 +: STATION_BITS];
  endfunction
  function automatic logic [7:0] f_hops(input logic [EW-1:0] e);
    f_hops = e[TIME_BITS +: 8];
  endfunction
  function automatic logic [TIME_BITS-1:0] f_exp(input logic [EW-1:0] e);
    f_exp = e[TIME_BITS-1:0];
  endfunction

  assign busy      = (state != lrt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign to_wide   = {{TIME_BITS{1'b0}}, expiry_timeout};

  assign idx    = pos[IW-1:0];
  assign tail   = IW'(count - CW'(1));
  assign cur    = ent[idx];
  assign tail_e = ent[tail];
  assign new_e  = {dest_r, trn_r, len_r, exp_r};
  assign at_end = (pos >= count);
  assign dest_hit = (f_dest(cur) == dest_r);
  assign improve  = (f_hops(cur) > len_r) ||
                    ((f_hops(cur) == len_r) && (f_trn(cur) != trn_r));
  assign cnt8 = 8'(count);
  assign lim8 = (table_limit == 5'd0) ? 8'd1 :
                ({3'd0, table_limit} > 8'(TABLE_DEPTH)) ? 8'(TABLE_DEPTH) :
                {3'd0, table_limit};
  assign evict_go = (cnt8 >= lim8) && (nres < RB'(lrt_pkg::MAX_RESULTS - 1));
  assign room     = (count < CW'(TABLE_DEPTH));

  always_comb begin
    case (cmd_r)
      lrt_pkg::CMD_REMOVE: sweep_hit = (f_trn(cur) == trn_r);
      lrt_pkg::CMD_EXPIRE: sweep_hit = (f_exp(cur) <= now_r);
      default:             sweep_hit = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lrt_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd == lrt_pkg::CMD_UPDATE || cmd == lrt_pkg::CMD_LOOKUP) begin
            state_next = lrt_pkg::ST_FIND;
          end else if (cmd == lrt_pkg::CMD_REMOVE || cmd == lrt_pkg::CMD_EXPIRE ||
                       cmd == lrt_pkg::CMD_CLEAR) begin
            state_next = lrt_pkg::ST_SWEEP;
          end else begin
            state_next = lrt_pkg::ST_DONE;
          end
        end
      end
      lrt_pkg::ST_FIND: begin
        if (at_end) begin
          state_next = (cmd_r == lrt_pkg::CMD_UPDATE) ? lrt_pkg::ST_EVICT : lrt_pkg::ST_DONE;
        end else if (dest_hit) begin
          state_next = lrt_pkg::ST_DONE;
        end
      end
      lrt_pkg::ST_EVICT: begin
        if (!evict_go) begin
          state_next = lrt_pkg::ST_DONE;
        end
      end
      lrt_pkg::ST_SWEEP: begin
        if (at_end || nres == RB'(lrt_pkg::MAX_RESULTS)) begin
          state_next = lrt_pkg::ST_DONE;
        end
      end
      lrt_pkg::ST_DONE: state_next = lrt_pkg::ST_IDLE;
      default:          state_next = lrt_pkg::ST_IDLE;
    endcase
  end

  // result words
  always_comb begin
    ctl    = '0;
    o_kind = lrt_pkg::EV_REMOVED;
    o_ent  = cur;
    case (state)
      lrt_pkg::ST_FIND: begin
        if (at_end) begin
          if (cmd_r == lrt_pkg::CMD_LOOKUP) begin
            ctl.emit = 1'b1;
            o_kind   = lrt_pkg::EV_MISS;
            o_ent    = {dest_r, {STATION_BITS{1'b1}}, 8'hFF, {TIME_BITS{1'b0}}};
          end
        end else if (dest_hit) begin
          if (cmd_r == lrt_pkg::CMD_LOOKUP) begin
            ctl.emit = 1'b1;
            o_kind   = lrt_pkg::EV_HIT;
          end else if (improve) begin
            ctl.emit = 1'b1;
            o_kind   = lrt_pkg::EV_UPDATED;
            o_ent    = {f_dest(cur), trn_r, len_r, exp_r};
          end
        end
      end
      lrt_pkg::ST_EVICT: begin
        if (evict_go) begin
          ctl.emit = 1'b1;
          o_ent    = tail_e;
        end else if (room) begin
          ctl.emit = 1'b1;
          o_kind   = lrt_pkg::EV_ADDED;
          o_ent    = new_e;
        end
      end
      lrt_pkg::ST_SWEEP: begin
        if (!at_end && nres != RB'(lrt_pkg::MAX_RESULTS) && sweep_hit) begin
          ctl.emit = 1'b1;
        end
      end
      lrt_pkg::ST_DONE: ctl.flush = 1'b1;
      default:          ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lrt_pkg::ST_IDLE;
      count          <= '0;
      pos            <= '0;
      nres           <= '0;
      table_limit    <= lrt_pkg::LIMIT_RESET;
      expiry_timeout <= lrt_pkg::TIMEOUT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lrt_pkg::REG_TABLE_LIMIT) begin
          table_limit <= cfg_data[4:0];
        end else if (cfg_index == lrt_pkg::REG_EXPIRY_TIMEOUT) begin
          expiry_timeout <= cfg_data;
        end
      end
      if (ctl.emit) begin
        nres <= nres + RB'(1);
      end
      case (state)
        lrt_pkg::ST_IDLE: begin
          pos  <= '0;
          nres <= '0;
        end
        lrt_pkg::ST_FIND: begin
          if (!at_end && !dest_hit) begin
            pos <= pos + CW'(1);
          end
        end
        lrt_pkg::ST_EVICT: begin
          if (evict_go) begin
            count <= count - CW'(1);
          end else if (room) begin
            count <= count + CW'(1);
          end
        end
        lrt_pkg::ST_SWEEP: begin
          if (ctl.emit) begin
            count <= count - CW'(1);
          end else if (!at_end) begin
            pos <= pos + CW'(1);
          end
        end
        default: pos <= pos;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd;
      dest_r <= dest_id;
      trn_r  <= transit_id;
      len_r  <= hop_length;
      now_r  <= now_ticks;
      exp_r  <= now_ticks + to_wide[TIME_BITS-1:0];
    end
    case (state)
      lrt_pkg::ST_FIND: begin
        if (!at_end && dest_hit) begin
          if (cmd_r == lrt_pkg::CMD_LOOKUP) begin
            for (int i = 1; i < TABLE_DEPTH; i++) begin
              if (IW'(i) <= idx) begin
                ent[i] <= ent[i-1];
              end
            end
            ent[0] <= cur;
          end else if (improve) begin
            ent[idx] <= {f_dest(cur), trn_r, len_r, exp_r};
          end
        end
      end
      lrt_pkg::ST_EVICT: begin
        if (!evict_go && room) begin
          for (int i = 1; i < TABLE_DEPTH; i++) begin
            ent[i] <= ent[i-1];
          end
          ent[0] <= new_e;
        end
      end
      lrt_pkg::ST_SWEEP: begin
        if (ctl.emit) begin
          for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            if (IW'(i) >= idx) begin
              ent[i] <= ent[i+1];
            end
          end
        end
      end
      default: ent[0] <= ent[0];
    endcase
  end

  lrt_out_stage #(
    .STATION_BITS(STATION_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .in_kind      (o_kind),
    .in_dest      (f_dest(o_ent)),
    .in_transit   (f_trn(o_ent)),
    .in_length    (f_hops(o_ent)),
    .in_expiry    (f_exp(o_ent)),
    .pend_valid   (pend_valid),
    .strobe       (strobe),
    .event_kind   (event_kind),
    .route_dest   (route_dest),
    .route_transit(route_transit),
    .route_length (route_length),
    .route_expiry (route_expiry),
    .last         (last)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == lrt_pkg::ST_IDLE) |-> !pend_valid)
    else $error("held word left behind at idle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("word delivered outside a command");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == lrt_pkg::ST_DONE) |=> !busy)
    else $error("sequencer did not return to idle");

endmodule

/* src/lrt_out_stage.sv */
// result staging: holds one word back so the final word can carry last
module lrt_out_stage #(
  parameter int STATION_BITS = lrt_pkg::STATION_BITS_DEF,
  parameter int TIME_BITS    = lrt_pkg::TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lrt_pkg::out_ctl_t       ctl,
  input  logic [2:0]              in_kind,
  input  logic [STATION_BITS-1:0] in_dest,
  input  logic [STATION_BITS-1:0] in_transit,
  input  logic [7:0]              in_length,
  input  logic [TIME_BITS-1:0]    in_expiry,
  output logic                    pend_valid,
  output logic                    strobe,
  output logic [2:0]              event_kind,
  output logic [STATION_BITS-1:0] route_dest,
  output logic [STATION_BITS-1:0] route_transit,
  output logic [7:0]              route_length,
  output logic [TIME_BITS-1:0]    route_expiry,
  output logic                    last
);

  logic [2:0]              p_kind;
  logic [STATION_BITS-1:0] p_dest;
  logic [STATION_BITS-1:0] p_transit;
  logic [7:0]              p_length;
  logic [TIME_BITS-1:0]    p_expiry;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      if (ctl.emit) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          strobe <= 1'b1;
        end
      end else if (ctl.flush && pend_valid) begin
        pend_valid <= 1'b0;
        strobe     <= 1'b1;
        last       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.emit || ctl.flush) && pend_valid) begin
      event_kind    <= p_kind;
      route_dest    <= p_dest;
      route_transit <= p_transit;
      route_length  <= p_length;
      route_expiry  <= p_expiry;
    end
    if (ctl.emit) begin
      p_kind    <= in_kind;
      p_dest    <= in_dest;
      p_transit <= in_transit;
      p_length  <= in_length;
      p_expiry  <= in_expiry;
    end
  end

endmodule
